FILE: hw/rtl/stepper_ramp_move_controller_macros.svh
// Assertion macros of the stepper ramp move controller RTL.
`ifndef STEPPER_RAMP_MOVE_CONTROLLER_MACROS_SVH
`define STEPPER_RAMP_MOVE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SRMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srmc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srmc assertion failed");
`else
`define SRMC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/srmc_pkg.sv
// Types and constants of the stepper ramp move controller.
`timescale 1ns / 1ps
package srmc_pkg;

    localparam int SPEED_BITS    = 28;
    localparam int STEP_BITS     = 32;
    localparam int REPORT_BITS   = 16;
    localparam int COUNT_BITS    = 31;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int FRAC_SHIFT    = 40;
    localparam int PROD_BITS     = SPEED_BITS + STEP_BITS;
    localparam int STEPS_N_BITS  = PROD_BITS + 1 - FRAC_SHIFT;

    typedef logic [OP_BITS-1:0]      t_op;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_MOVE  = 2'd1;
    localparam t_op OP_SPEED = 2'd2;

    localparam t_cfg_idx CFG_RAMP_STEP       = 2'd0;
    localparam t_cfg_idx CFG_STEPS_PER_RPM   = 2'd1;
    localparam t_cfg_idx CFG_REPORT_INTERVAL = 2'd2;

    localparam logic [SPEED_BITS-1:0]  RST_RAMP_STEP       = SPEED_BITS'(65536);
    localparam logic [STEP_BITS-1:0]   RST_STEPS_PER_RPM   = STEP_BITS'(1048576);
    localparam logic [REPORT_BITS-1:0] RST_REPORT_INTERVAL = REPORT_BITS'(10);

    // continuous mode ignores changes of 0.01 rpm or less
    localparam logic [SPEED_BITS-1:0] STEADY_BAND = SPEED_BITS'(655);
    // half an LSB of the steps-per-tick result, for round half up
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_SHIFT - 1);

    typedef struct packed {
        t_op                   operation;
        logic [COUNT_BITS-1:0] step_count;
        logic [SPEED_BITS-1:0] target_rpm;
        logic                  move_direction;
        logic                  speed_active;
    } t_item;

    typedef struct packed {
        logic                  drive_enable;
        logic                  drive_direction;
        logic [SPEED_BITS-1:0] drive_rpm;
        logic                  move_done;
        logic                  done_flag;
        logic                  report_now;
    } t_result;

    typedef struct packed {
        logic [SPEED_BITS-1:0]  ramp_step;
        logic [STEP_BITS-1:0]   steps_per_rpm_tick;
        logic [REPORT_BITS-1:0] report_interval;
    } t_cfg;

endpackage

FILE: hw/rtl/srmc_req_if.sv
// Request channel of the stepper ramp move controller.
`timescale 1ns / 1ps
interface srmc_req_if import srmc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_op                   operation;
    logic [COUNT_BITS-1:0] step_count;
    logic [SPEED_BITS-1:0] target_rpm;
    logic                  move_direction;
    logic                  speed_active;

    modport source (
        output valid, operation, step_count, target_rpm, move_direction, speed_active,
        input  ready
    );
    modport sink (
        input  valid, operation, step_count, target_rpm, move_direction, speed_active,
        output ready
    );
endinterface

FILE: hw/rtl/srmc_res_if.sv
// Result channel of the stepper ramp move controller.
`timescale 1ns / 1ps
interface srmc_res_if import srmc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  drive_enable;
    logic                  drive_direction;
    logic [SPEED_BITS-1:0] drive_rpm;
    logic                  move_done;
    logic                  done_flag;
    logic                  report_now;

    modport source (
        output valid, drive_enable, drive_direction, drive_rpm, move_done, done_flag,
               report_now,
        input  ready
    );
    modport sink (
        input  valid, drive_enable, drive_direction, drive_rpm, move_done, done_flag,
               report_now,
        output ready
    );
endinterface

FILE: hw/rtl/srmc_cfg.sv
// Configuration registers of the stepper ramp move controller.
`timescale 1ns / 1ps
module srmc_cfg import srmc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step          <= RST_RAMP_STEP;
            r_cfg.steps_per_rpm_tick <= RST_STEPS_PER_RPM;
            r_cfg.report_interval    <= RST_REPORT_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAMP_STEP:       r_cfg.ramp_step          <= i_cfg_data[SPEED_BITS-1:0];
                CFG_STEPS_PER_RPM:   r_cfg.steps_per_rpm_tick <= i_cfg_data[STEP_BITS-1:0];
                CFG_REPORT_INTERVAL: r_cfg.report_interval    <= i_cfg_data[REPORT_BITS-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/srmc_in_reg.sv
// Input register stage of the stepper ramp move controller.
`timescale 1ns / 1ps
module srmc_in_reg import srmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // refill in the same cycle the held request moves on
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/srmc_engine.sv
// Move state, ramp and step accounting with the result register.
`timescale 1ns / 1ps
`include "stepper_ramp_move_controller_macros.svh"
module srmc_engine import srmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    logic                   r_counted_active, n_counted_active;
    logic                   r_continuous_active, n_continuous_active;
    logic [SPEED_BITS-1:0]  r_goal_speed, n_goal_speed;
    logic [SPEED_BITS-1:0]  r_present_speed, n_present_speed;
    logic [COUNT_BITS-1:0]  r_steps_left, n_steps_left;
    logic                   r_wanted_direction, n_wanted_direction;
    logic                   r_enable, n_enable;
    logic                   r_direction, n_direction;
    logic                   r_finished, n_finished;
    logic [REPORT_BITS-1:0] r_tick_count, n_tick_count;
    logic                   n_done, n_report;

    logic                   r_res_valid;
    t_result                r_res;

    logic                   w_take;
    logic [SPEED_BITS:0]    w_up_sum;
    logic [SPEED_BITS-1:0]  w_down_gap;
    logic [SPEED_BITS-1:0]  w_ramped;
    logic [PROD_BITS-1:0]   w_prod;
    logic [PROD_BITS:0]     w_rounded;
    logic [STEPS_N_BITS-1:0] w_steps_raw;
    logic [COUNT_BITS-1:0]  w_steps;
    logic [SPEED_BITS-1:0]  w_speed_delta;
    logic [REPORT_BITS-1:0] w_tick_inc;

    assign w_take = i_valid && (!r_res_valid || i_res_ready);
    assign o_take = w_take;

    // ramp toward the goal, clamped so it never passes it
    assign w_up_sum   = {1'b0, r_present_speed} + {1'b0, i_cfg.ramp_step};
    assign w_down_gap = r_present_speed - r_goal_speed;

    always_comb begin
        if (r_present_speed < r_goal_speed) begin
            w_ramped = (w_up_sum > {1'b0, r_goal_speed}) ? r_goal_speed
                                                         : w_up_sum[SPEED_BITS-1:0];
        end else if (r_present_speed > r_goal_speed) begin
            w_ramped = (w_down_gap < i_cfg.ramp_step) ? r_goal_speed
                                                      : r_present_speed - i_cfg.ramp_step;
        end else begin
            w_ramped = r_present_speed;
        end
    end

    // microsteps this tick: round half up of speed * factor / 2^40, at least one
    assign w_prod      = {{STEP_BITS{1'b0}}, w_ramped}
                       * {{SPEED_BITS{1'b0}}, i_cfg.steps_per_rpm_tick};
    assign w_rounded   = {1'b0, w_prod} + ROUND_HALF;
    assign w_steps_raw = w_rounded[PROD_BITS:FRAC_SHIFT];
    assign w_steps     = (w_steps_raw == '0) ? COUNT_BITS'(1) : COUNT_BITS'(w_steps_raw);

    assign w_speed_delta = (w_ramped > r_present_speed) ? w_ramped - r_present_speed
                                                        : r_present_speed - w_ramped;
    assign w_tick_inc    = r_tick_count + REPORT_BITS'(1);

    always_comb begin
        n_counted_active    = r_counted_active;
        n_continuous_active = r_continuous_active;
        n_goal_speed        = r_goal_speed;
        n_present_speed     = r_present_speed;
        n_steps_left        = r_steps_left;
        n_wanted_direction  = r_wanted_direction;
        n_enable            = r_enable;
        n_direction         = r_direction;
        n_finished          = r_finished;
        n_tick_count        = r_tick_count;
        n_done              = 1'b0;
        n_report            = 1'b0;

        case (i_item.operation)
            OP_MOVE: begin
                if ((i_item.step_count != '0) && (i_item.target_rpm != '0)) begin
                    n_steps_left        = i_item.step_count;
                    n_counted_active    = 1'b1;
                    n_continuous_active = 1'b0;
                    n_goal_speed        = i_item.target_rpm;
                    n_present_speed     = '0;
                    n_wanted_direction  = i_item.move_direction;
                end
            end
            OP_SPEED: begin
                n_continuous_active = i_item.speed_active;
                if (i_item.speed_active) begin
                    n_goal_speed       = i_item.target_rpm;
                    n_wanted_direction = i_item.move_direction;
                    n_counted_active   = 1'b0;
                end else if (!r_counted_active) begin
                    n_goal_speed = '0;
                end
            end
            OP_TICK: begin
                if (r_counted_active) begin
                    n_enable    = 1'b1;
                    n_direction = r_wanted_direction;
                    if (w_steps >= r_steps_left) begin
                        n_steps_left     = '0;
                        n_present_speed  = '0;
                        n_enable         = 1'b0;
                        n_counted_active = 1'b0;
                        n_finished       = 1'b1;
                        n_done           = 1'b1;
                    end else begin
                        n_present_speed = w_ramped;
                        n_steps_left    = r_steps_left - w_steps;
                    end
                end else if (r_continuous_active) begin
                    if (w_speed_delta > STEADY_BAND) begin
                        n_present_speed = w_ramped;
                        n_enable        = 1'b1;
                        n_direction     = r_wanted_direction;
                    end
                end else if (r_present_speed != '0) begin
                    n_present_speed = '0;
                    n_enable        = 1'b0;
                end

                if (w_tick_inc >= i_cfg.report_interval) begin
                    n_report     = 1'b1;
                    n_tick_count = '0;
                end else begin
                    n_tick_count = w_tick_inc;
                end
            end
            default: ;  // unused operation, no change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counted_active    <= 1'b0;
            r_continuous_active <= 1'b0;
            r_goal_speed        <= '0;
            r_present_speed     <= '0;
            r_steps_left        <= '0;
            r_wanted_direction  <= 1'b0;
            r_enable            <= 1'b0;
            r_direction         <= 1'b0;
            r_finished          <= 1'b0;
            r_tick_count        <= '0;
        end else if (w_take) begin
            r_counted_active    <= n_counted_active;
            r_continuous_active <= n_continuous_active;
            r_goal_speed        <= n_goal_speed;
            r_present_speed     <= n_present_speed;
            r_steps_left        <= n_steps_left;
            r_wanted_direction  <= n_wanted_direction;
            r_enable            <= n_enable;
            r_direction         <= n_direction;
            r_finished          <= n_finished;
            r_tick_count        <= n_tick_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_take) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res.drive_enable    <= n_enable;
            r_res.drive_direction <= n_direction;
            r_res.drive_rpm       <= n_present_speed;
            r_res.move_done       <= n_done;
            r_res.done_flag       <= n_finished;
            r_res.report_now      <= n_report;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `SRMC_ASSERT_IMPL(a_modes_exclusive, i_clk, i_rst_n, 1'b1, !(r_counted_active && r_continuous_active))
    `SRMC_ASSERT_NEXT(a_done_stops_move, i_clk, i_rst_n, w_take && n_done, !r_counted_active && r_finished && !r_enable && (r_steps_left == '0))
    `SRMC_ASSERT_NEXT(a_report_clears_count, i_clk, i_rst_n, w_take && n_report, r_tick_count == '0)
    `SRMC_ASSERT_IMPL(a_done_result_idle, i_clk, i_rst_n, r_res_valid && r_res.move_done, r_res.done_flag && !r_res.drive_enable && (r_res.drive_rpm == '0))

endmodule

FILE: hw/rtl/stepper_ramp_move_controller.sv
// Top level of the stepper ramp move controller.
`timescale 1ns / 1ps
//  channel   direction  handshake            payload
//  i_req     in         valid/ready          operation, step_count, target_rpm,
//                                            move_direction, speed_active
//  o_res     out        valid/ready          drive_enable, drive_direction, drive_rpm,
//                                            move_done, done_flag, report_now
//  i_cfg_*   in         write enable only    register index, 32-bit data
//
//  A request passes through the input register, then through the ramp,
//  steps-per-tick multiply and count compare into the result register.
//  One request per cycle is sustained while results are taken; the loop from the move
//  state registers through ramp, multiply and compare back into them sets that cycle.
//  Reset is synchronous and active low; it clears the move state, drops both
//  valids and loads the configuration defaults.
//  A stalled result holds in the result register while one more request
//  waits in the input register; ready then drops until the result is taken.
module stepper_ramp_move_controller import srmc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    srmc_req_if.sink                 i_req,
    srmc_res_if.source               o_res,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_item   w_req_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_take;
    t_result w_res;

    // pack the request fields for the pipeline
    assign w_req_item.operation      = i_req.operation;
    assign w_req_item.step_count     = i_req.step_count;
    assign w_req_item.target_rpm     = i_req.target_rpm;
    assign w_req_item.move_direction = i_req.move_direction;
    assign w_req_item.speed_active   = i_req.speed_active;

    srmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register: takes a new request while empty or while the held one moves on
    srmc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (w_req_item),
        .o_valid (w_held_valid),
        .o_item  (w_held_item),
        .i_take  (w_take)
    );

    // state update and result register, one request per cycle while the result is taken
    srmc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_held_valid),
        .i_item      (w_held_item),
        .o_take      (w_take),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign o_res.drive_enable    = w_res.drive_enable;
    assign o_res.drive_direction = w_res.drive_direction;
    assign o_res.drive_rpm       = w_res.drive_rpm;
    assign o_res.move_done       = w_res.move_done;
    assign o_res.done_flag       = w_res.done_flag;
    assign o_res.report_now      = w_res.report_now;

endmodule
